// ----- hw/rtl/circle_point_generator_3d_macros.svh -----
// ----------------------------------------------------------------------------
// Circle point generator macros
// Assertion helpers shared by the RTL files of the circle point generator.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_POINT_GENERATOR_3D_MACROS_SVH
`define CIRCLE_POINT_GENERATOR_3D_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CPG_ASSERT_IMP(lbl, ante, cons, msg) \
  `CPG_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/cpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Circle point generator package
// Shared types, stage counts and rounding helper.
// ----------------------------------------------------------------------------
package cpg_pkg;

  // Register stages of the sine/cosine pipeline and of the point pipeline.
  localparam int unsigned CPG_SC_STAGES = 25;
  localparam int unsigned CPG_PT_STAGES = 6;

  typedef enum logic [2:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4,
    REG_CENTER_Z = 3'd5,
    REG_RADIUS   = 3'd6
  } cpg_reg_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SQRT,
    BS_LOAD,
    BS_DIV,
    BS_MUL,
    BS_RND
  } cpg_bstate_e;

  // Plane basis in Q30.
  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } cpg_basis_t;

  // Drop 30 fraction bits, round to nearest with halves away from zero.
  function automatic logic signed [71:0] cpg_round_q30(input logic signed [71:0] v);
    logic [71:0] m;
    logic [71:0] q;
    m = v[71] ? 72'(-v) : 72'(v);
    q = (m + (72'd1 << 29)) >> 30;
    return v[71] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ----- hw/rtl/circle_point_generator_3d.sv -----
// ----------------------------------------------------------------------------
// Circle point generator in a 3-D plane
// Returns the point at a given angle step on a configured circle.
// ----------------------------------------------------------------------------
// Usage: write the normal, center and radius through the cfg port (index in
// the order normal x/y/z, center x/y/z, radius; unknown indexes are dropped).
// Each write restarts the basis unit, which holds in_ready_o low during the
// write and after it while two 32-step square roots and four 64-step
// divisions run. After reset the same pass runs once on the reset values.
// Send angle steps on the input channel; each transaction yields one point
// transaction on the output channel, in order.
// Throughput: one transaction per cycle while the basis unit is idle and the
// receiver is ready, through the 31-stage pipeline (phase, Taylor terms,
// quadrant fold, basis combine, radius scaling, saturation).
// When the receiver stalls, stages hold their items; bubbles still close up,
// so input is taken until every stage is full, then in_ready_o drops.
// Reset clears all valid bits and loads the reset configuration.
// ----------------------------------------------------------------------------
`include "circle_point_generator_3d_macros.svh"

module circle_point_generator_3d import cpg_pkg::*; #(
  parameter int unsigned ANGLE_STEPS = 360,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [8:0]         angle_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] point_x_o,
  output logic signed [47:0] point_y_o,
  output logic signed [47:0] point_z_o,
  output logic               degenerate_o
);

  localparam int unsigned NumStages = CPG_SC_STAGES + CPG_PT_STAGES;

  // Configuration registers
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [31:0]        radius_q;
  logic               start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q     <= 16'sd16384;
      ny_q     <= '0;
      nz_q     <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      radius_q <= 32'd131072;
      start_q  <= 1'b1;
    end else begin
      // Kick the basis unit in the cycle after each write, when the new value is in
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NORMAL_X: nx_q     <= cfg_data_i[15:0];
          REG_NORMAL_Y: ny_q     <= cfg_data_i[15:0];
          REG_NORMAL_Z: nz_q     <= cfg_data_i[15:0];
          REG_CENTER_X: cx_q     <= cfg_data_i;
          REG_CENTER_Y: cy_q     <= cfg_data_i;
          REG_CENTER_Z: cz_q     <= cfg_data_i;
          REG_RADIUS:   radius_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Basis unit
  cpg_basis_t basis;
  logic       basis_busy, busy;

  cpg_basis u_basis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .nx_i    (nx_q),
    .ny_i    (ny_q),
    .nz_i    (nz_q),
    .busy_o  (basis_busy),
    .basis_o (basis)
  );

  assign busy = basis_busy || start_q;

  // Valid bits travel with the data; a stage advances when empty or drained
  logic [NumStages-1:0] vld_q, vld_d, adv;
  logic                 in_fire, out_fire;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0] && !busy && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q[NumStages-1];
  assign out_fire   = out_valid_o && out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) vld_d[0] = in_fire;
    for (int i = 1; i < NumStages; i++) begin
      if (adv[i]) vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Datapath
  logic signed [31:0] cos_w, sin_w;
  logic               degen;

  assign degen = (nx_q == 16'sd0) && (ny_q == 16'sd0);

  cpg_sincos #(
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_sincos (
    .clk_i   (clk_i),
    .en_i    (adv[CPG_SC_STAGES-1:0]),
    .angle_i (angle_index_i),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  cpg_point #(
    .FRAC_BITS (FRAC_BITS)
  ) u_point (
    .clk_i        (clk_i),
    .en_i         (adv[NumStages-1:CPG_SC_STAGES]),
    .cos_i        (cos_w),
    .sin_i        (sin_w),
    .basis_i      (basis),
    .center_x_i   (cx_q),
    .center_y_i   (cy_q),
    .center_z_i   (cz_q),
    .radius_i     (radius_q),
    .degen_i      (degen),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .degenerate_o (degenerate_o)
  );

  // A write must close the input until the basis pass has started
  `CPG_ASSERT(a_cfg_blocks_input, cfg_we_i |=> !in_ready_o, "input open right after cfg write")
  // Occupancy moves only by accepted and delivered transactions
  `CPG_ASSERT(a_occupancy, 1'b1 |=> ($countones(vld_q) == $countones($past(vld_q)) + $past(in_fire) - $past(out_fire)), "pipeline lost or repeated a transaction")
  // A full, stalled pipeline must refuse input
  `CPG_ASSERT_IMP(a_full_stall, (&vld_q) && !out_ready_i, !in_ready_o, "input taken while full and stalled")

endmodule

// ----- hw/rtl/cpg_basis.sv -----
// ----------------------------------------------------------------------------
// Circle point generator basis unit
// Sequencer computing the unit in-plane basis vectors from the normal.
// ----------------------------------------------------------------------------
module cpg_basis import cpg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] nx_i,
  input  logic signed [15:0] ny_i,
  input  logic signed [15:0] nz_i,
  output logic               busy_o,
  output cpg_basis_t         basis_o
);

  cpg_bstate_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [1:0]  op_q, op_d;

  logic [63:0] rad_q [2];
  logic [33:0] rem_q [2];
  logic [31:0] root_q [2];

  logic [63:0] dvd_q;
  logic [31:0] drem_q, den_q;
  logic        neg_q;
  logic signed [31:0] ux_q, uy_q, cq_q, dq_q, vx_q, vy_q;
  logic signed [63:0] pvx_q, pvy_q;

  logic [31:0] sq_x, sq_y, sq_z, s_sum, t_sum;
  logic [16:0] mag_x, mag_y, mag_z;

  assign sq_x  = 32'(nx_i * nx_i);
  assign sq_y  = 32'(ny_i * ny_i);
  assign sq_z  = 32'(nz_i * nz_i);
  assign s_sum = sq_x + sq_y;
  assign t_sum = s_sum + sq_z;
  assign mag_x = nx_i[15] ? 17'(-18'(nx_i)) : 17'(nx_i);
  assign mag_y = ny_i[15] ? 17'(-18'(ny_i)) : 17'(ny_i);
  assign mag_z = nz_i[15] ? 17'(-18'(nz_i)) : 17'(nz_i);

  // Divider step
  logic [32:0] div_w;
  logic        div_ge;
  logic [63:0] dvd_next;
  logic [31:0] drem_next;
  logic signed [31:0] quo;

  assign div_w     = {drem_q, dvd_q[63]};
  assign div_ge    = div_w >= {1'b0, den_q};
  assign drem_next = div_ge ? 32'(div_w - {1'b0, den_q}) : div_w[31:0];
  assign dvd_next  = {dvd_q[62:0], div_ge};
  assign quo       = neg_q ? -$signed(dvd_next[31:0]) : $signed(dvd_next[31:0]);

  // Square root steps, one lane per root
  logic [35:0] sq_w   [2];
  logic [35:0] sq_try [2];
  logic        sq_ge  [2];

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    assign sq_w[l]   = {rem_q[l], rad_q[l][63:62]};
    assign sq_try[l] = {2'b00, root_q[l], 2'b01};
    assign sq_ge[l]  = sq_w[l] >= sq_try[l];

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rad_q[l]  <= (l == 0) ? {s_sum, 32'd0} : {t_sum, 32'd0};
        rem_q[l]  <= '0;
        root_q[l] <= '0;
      end else if (state_q == BS_SQRT) begin
        rad_q[l]  <= {rad_q[l][61:0], 2'b00};
        rem_q[l]  <= sq_ge[l] ? 34'(sq_w[l] - sq_try[l]) : sq_w[l][33:0];
        root_q[l] <= {root_q[l][30:0], sq_ge[l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      cnt_q   <= '0;
      op_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    unique case (state_q)
      BS_IDLE: ;
      BS_SQRT: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = BS_LOAD;
          cnt_d   = '0;
          op_d    = '0;
        end
      end
      BS_LOAD: state_d = BS_DIV;
      BS_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          cnt_d = '0;
          if (op_q == 2'd3) begin
            state_d = BS_MUL;
          end else begin
            op_d    = op_q + 2'd1;
            state_d = BS_LOAD;
          end
        end
      end
      BS_MUL: state_d = BS_RND;
      BS_RND: state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
    // Restart on every configuration write
    if (start_i) begin
      state_d = BS_SQRT;
      cnt_d   = '0;
      op_d    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BS_LOAD) begin
      drem_q <= '0;
      unique case (op_q)
        2'd0: begin
          dvd_q <= (64'(mag_y) << 46) + 64'(root_q[0] >> 1);
          den_q <= root_q[0];
          neg_q <= ny_i[15];
        end
        2'd1: begin
          dvd_q <= (64'(mag_x) << 46) + 64'(root_q[0] >> 1);
          den_q <= root_q[0];
          neg_q <= !nx_i[15] && (nx_i != 16'sd0);
        end
        2'd2: begin
          dvd_q <= (64'(mag_z) << 46) + 64'(root_q[1] >> 1);
          den_q <= root_q[1];
          neg_q <= nz_i[15];
        end
        default: begin
          dvd_q <= (64'(root_q[0]) << 30) + 64'(root_q[1] >> 1);
          den_q <= root_q[1];
          neg_q <= 1'b0;
        end
      endcase
    end else if (state_q == BS_DIV) begin
      dvd_q  <= dvd_next;
      drem_q <= drem_next;
      if (cnt_q == 6'd63) begin
        unique case (op_q)
          2'd0:    ux_q <= quo;
          2'd1:    uy_q <= quo;
          2'd2:    cq_q <= quo;
          default: dq_q <= quo;
        endcase
      end
    end
    if (state_q == BS_MUL) begin
      pvx_q <= 64'(-uy_q) * 64'(cq_q);
      pvy_q <= 64'(ux_q) * 64'(cq_q);
    end
    if (state_q == BS_RND) begin
      vx_q <= 32'(cpg_round_q30(72'(pvx_q)));
      vy_q <= 32'(cpg_round_q30(72'(pvy_q)));
    end
  end

  assign busy_o     = state_q != BS_IDLE;
  assign basis_o.ux = ux_q;
  assign basis_o.uy = uy_q;
  assign basis_o.vx = vx_q;
  assign basis_o.vy = vy_q;
  assign basis_o.vz = -dq_q;

endmodule

// ----- hw/rtl/cpg_sincos.sv -----
// ----------------------------------------------------------------------------
// Circle point generator sine/cosine pipeline
// Angle index to phase, then Taylor series for sine and cosine in Q30.
// ----------------------------------------------------------------------------
module cpg_sincos import cpg_pkg::*; #(
  parameter int unsigned ANGLE_STEPS = 360
) (
  input  logic                     clk_i,
  input  logic [CPG_SC_STAGES-1:0] en_i,
  input  logic [8:0]               angle_i,
  output logic signed [31:0]       cos_o,
  output logic signed [31:0]       sin_o
);

  localparam logic [63:0] Steps   = 64'(ANGLE_STEPS);
  localparam logic [63:0] ModMul  = ((64'd1 << 21) + Steps - 64'd1) / Steps;
  localparam logic [63:0] Quo     = (64'd1 << 32) / Steps;
  localparam logic [63:0] Rem     = (64'd1 << 32) % Steps;
  localparam logic [63:0] FracMul = ((64'd1 << 37) + Steps - 64'd1) / Steps;
  localparam logic [63:0] HalfPi  = 64'd1686629713;
  localparam logic [63:0] RndQ30  = 64'd1 << 29;

  logic [8:0]  ang_q, k1_q, q1_q;
  logic [11:0] kk2_q, f4_q;
  logic [31:0] a3_q, kq3_q, kq4_q, phase;
  logic [1:0]  quad5_q, quad6_q;
  logic [29:0] rem5_q;
  logic [30:0] x6_q;
  logic signed [31:0] cos_q, sin_q;

  // Phase stages
  assign phase = kq4_q + 32'(f4_q);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) ang_q <= angle_i;
    if (en_i[1]) begin
      k1_q <= ang_q;
      q1_q <= 9'((64'(ang_q) * ModMul) >> 21);
    end
    if (en_i[2]) kk2_q <= 12'(32'(k1_q) - 32'(q1_q) * 32'(Steps));
    if (en_i[3]) begin
      a3_q  <= 32'(32'(kk2_q) * 32'(Rem) + 32'(Steps >> 1));
      kq3_q <= 32'(32'(kk2_q) * 32'(Quo));
    end
    if (en_i[4]) begin
      f4_q  <= 12'((64'(a3_q) * FracMul) >> 37);
      kq4_q <= kq3_q;
    end
    if (en_i[5]) begin
      quad5_q <= phase[31:30];
      rem5_q  <= phase[29:0];
    end
    if (en_i[6]) begin
      x6_q    <= 31'((64'(rem5_q) * HalfPi + RndQ30) >> 30);
      quad6_q <= quad5_q;
    end
  end

  // Taylor terms: one multiply stage and one constant-divide stage per term
  logic [31:0]        st_q  [9];
  logic [31:0]        ct_q  [9];
  logic signed [33:0] ss_q  [9];
  logic signed [33:0] cs_q  [9];
  logic [31:0]        x2_q  [9];
  logic [1:0]         qd_q  [9];

  logic [31:0]        sp_q  [8];
  logic [31:0]        cp_q  [8];
  logic signed [33:0] ssa_q [8];
  logic signed [33:0] csa_q [8];
  logic [31:0]        x2a_q [8];
  logic [1:0]         qda_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      st_q[0] <= 32'(x6_q);
      ct_q[0] <= 32'd1 << 30;
      ss_q[0] <= 34'(x6_q);
      cs_q[0] <= 34'sd1 << 30;
      x2_q[0] <= 32'((64'(x6_q) * 64'(x6_q) + RndQ30) >> 30);
      qd_q[0] <= quad6_q;
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_term
    localparam logic [79:0] DivS = 80'((2 * g + 2) * (2 * g + 3));
    localparam logic [79:0] DivC = 80'((2 * g + 1) * (2 * g + 2));
    localparam logic [79:0] MulS = ((80'd1 << 41) + DivS - 80'd1) / DivS;
    localparam logic [79:0] MulC = ((80'd1 << 41) + DivC - 80'd1) / DivC;

    logic [31:0] st_new, ct_new;
    assign st_new = 32'((80'(sp_q[g] + 32'(DivS >> 1)) * MulS) >> 41);
    assign ct_new = 32'((80'(cp_q[g] + 32'(DivC >> 1)) * MulC) >> 41);

    always_ff @(posedge clk_i) begin
      if (en_i[8+2*g]) begin
        sp_q[g]  <= 32'((64'(st_q[g]) * 64'(x2_q[g])) >> 30);
        cp_q[g]  <= 32'((64'(ct_q[g]) * 64'(x2_q[g])) >> 30);
        ssa_q[g] <= ss_q[g];
        csa_q[g] <= cs_q[g];
        x2a_q[g] <= x2_q[g];
        qda_q[g] <= qd_q[g];
      end
      if (en_i[9+2*g]) begin
        st_q[g+1] <= st_new;
        ct_q[g+1] <= ct_new;
        // Odd terms subtract, even terms add
        if (g % 2 == 0) begin
          ss_q[g+1] <= ssa_q[g] - $signed(34'(st_new));
          cs_q[g+1] <= csa_q[g] - $signed(34'(ct_new));
        end else begin
          ss_q[g+1] <= ssa_q[g] + $signed(34'(st_new));
          cs_q[g+1] <= csa_q[g] + $signed(34'(ct_new));
        end
        x2_q[g+1] <= x2a_q[g];
        qd_q[g+1] <= qda_q[g];
      end
    end
  end

  // Clamp to [0, 1] and fold in the quadrant
  logic signed [31:0] s0, c0, cos_d, sin_d;

  assign s0 = ss_q[8] < 0 ? 32'sd0 :
              (ss_q[8] > (34'sd1 <<< 30) ? (32'sd1 <<< 30) : 32'(ss_q[8]));
  assign c0 = cs_q[8] < 0 ? 32'sd0 :
              (cs_q[8] > (34'sd1 <<< 30) ? (32'sd1 <<< 30) : 32'(cs_q[8]));

  always_comb begin
    case (qd_q[8])
      2'd0: begin cos_d = c0;  sin_d = s0;  end
      2'd1: begin cos_d = -s0; sin_d = c0;  end
      2'd2: begin cos_d = -c0; sin_d = -s0; end
      default: begin cos_d = s0; sin_d = -c0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[24]) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ----- hw/rtl/cpg_point.sv -----
// ----------------------------------------------------------------------------
// Circle point generator point pipeline
// Combines basis, sine/cosine, radius and center into saturated Q32.16 points.
// ----------------------------------------------------------------------------
module cpg_point import cpg_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic [CPG_PT_STAGES-1:0] en_i,
  input  logic signed [31:0]       cos_i,
  input  logic signed [31:0]       sin_i,
  input  cpg_basis_t               basis_i,
  input  logic signed [31:0]       center_x_i,
  input  logic signed [31:0]       center_y_i,
  input  logic signed [31:0]       center_z_i,
  input  logic [31:0]              radius_i,
  input  logic                     degen_i,
  output logic signed [47:0]       point_x_o,
  output logic signed [47:0]       point_y_o,
  output logic signed [47:0]       point_z_o,
  output logic                     degenerate_o
);

  localparam logic signed [63:0] OutMax = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] OutMin = -(64'sd1 <<< 47);

  logic signed [31:0] u_vec [3];
  logic signed [31:0] v_vec [3];
  logic signed [31:0] cen   [3];

  assign u_vec[0] = basis_i.ux;
  assign u_vec[1] = basis_i.uy;
  assign u_vec[2] = 32'sd0;
  assign v_vec[0] = basis_i.vx;
  assign v_vec[1] = basis_i.vy;
  assign v_vec[2] = basis_i.vz;
  assign cen[0]   = center_x_i;
  assign cen[1]   = center_y_i;
  assign cen[2]   = center_z_i;

  logic signed [63:0] pu_q   [3];
  logic signed [63:0] pv_q   [3];
  logic signed [64:0] sum_q  [3];
  logic signed [33:0] w_q    [3];
  logic signed [66:0] prod_q [3];
  logic signed [39:0] off_q  [3];
  logic signed [47:0] pt_q   [3];
  logic               degen_q;

  logic signed [63:0] pos [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = (64'(cen[a]) <<< FRAC_BITS) + (degen_i ? 64'sd0 : 64'(off_q[a]));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (en_i[0]) begin
        pu_q[a] <= 64'(u_vec[a]) * 64'(cos_i);
        pv_q[a] <= 64'(v_vec[a]) * 64'(sin_i);
      end
      if (en_i[1]) sum_q[a] <= 65'(pu_q[a]) + 65'(pv_q[a]);
      if (en_i[2]) w_q[a] <= 34'(cpg_round_q30(72'(sum_q[a])));
      if (en_i[3]) prod_q[a] <= 67'($signed({1'b0, radius_i})) * 67'(w_q[a]);
      if (en_i[4]) off_q[a] <= 40'(cpg_round_q30(72'(prod_q[a])));
      if (en_i[5]) begin
        pt_q[a] <= pos[a] > OutMax ? 48'(OutMax) :
                   (pos[a] < OutMin ? 48'(OutMin) : 48'(pos[a]));
      end
    end
    if (en_i[5]) degen_q <= degen_i;
  end

  assign point_x_o    = pt_q[0];
  assign point_y_o    = pt_q[1];
  assign point_z_o    = pt_q[2];
  assign degenerate_o = degen_q;

endmodule
